// ===== rtl/plain_column_payload_decoder_assert.svh =====
// Assertion shorthands used by the decoder's output queue.
`ifndef PLAIN_COLUMN_PAYLOAD_DECODER_ASSERT_SVH
`define PLAIN_COLUMN_PAYLOAD_DECODER_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define PCPD_CHECK(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("decoder check failed");

// When the first expression holds, the second holds in the next cycle.
`define PCPD_CHECK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decoder sequence check failed");

`endif

// ===== rtl/pcpd_pkg.sv =====
package pcpd_pkg;

  localparam int ROW_W = 17;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_BITMAP  = 3'd1;
  localparam logic [2:0] PH_OFFSETS = 3'd2;
  localparam logic [2:0] PH_VALUES  = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TRUNC     = 4'd1;
  localparam logic [3:0] ST_TRAILING  = 4'd2;
  localparam logic [3:0] ST_BM_LEN    = 4'd3;
  localparam logic [3:0] ST_NULLS     = 4'd4;
  localparam logic [3:0] ST_PADDING   = 4'd5;
  localparam logic [3:0] ST_OFF_LEN   = 4'd6;
  localparam logic [3:0] ST_OFF_ORDER = 4'd7;
  localparam logic [3:0] ST_OFF_NORM  = 4'd8;
  localparam logic [3:0] ST_FIXED_OFF = 4'd9;
  localparam logic [3:0] ST_VAL_LEN   = 4'd10;
  localparam logic [3:0] ST_BAD_BOOL  = 4'd11;
  localparam logic [3:0] ST_TOO_LONG  = 4'd12;
  localparam logic [3:0] ST_UNKNOWN   = 4'd13;

  localparam logic [3:0] CT_BOOL   = 4'd0;
  localparam logic [3:0] CT_I8     = 4'd1;
  localparam logic [3:0] CT_I16    = 4'd2;
  localparam logic [3:0] CT_I32    = 4'd3;
  localparam logic [3:0] CT_I64    = 4'd4;
  localparam logic [3:0] CT_U8     = 4'd5;
  localparam logic [3:0] CT_U16    = 4'd6;
  localparam logic [3:0] CT_U32    = 4'd7;
  localparam logic [3:0] CT_U64    = 4'd8;
  localparam logic [3:0] CT_F32    = 4'd9;
  localparam logic [3:0] CT_F64    = 4'd10;
  localparam logic [3:0] CT_TS     = 4'd11;
  localparam logic [3:0] CT_STRING = 4'd12;
  localparam logic [3:0] CT_BINARY = 4'd13;

  localparam logic [1:0] REG_COLUMN_TYPE = 2'd0;
  localparam logic [1:0] REG_ROWS        = 2'd1;
  localparam logic [1:0] REG_NULLS       = 2'd2;

  typedef struct packed {
    logic [3:0]       column_type;
    logic [ROW_W-1:0] rows_in_chunk;
    logic [ROW_W-1:0] declared_nulls;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] row;
    logic [63:0] value;
    logic [30:0] len;
    logic        is_null;
    logic [3:0]  code;
    logic        eoc;
  } result_t;

  // Log2 of the element width in bytes; valid only where fixed_known is set.
  function automatic logic [1:0] width_log2(input logic [3:0] ct);
    logic [1:0] w;
    w = 2'd0;
    unique case (ct)
      CT_BOOL, CT_I8, CT_U8: w = 2'd0;
      CT_I16, CT_U16: w = 2'd1;
      CT_I32, CT_U32, CT_F32: w = 2'd2;
      CT_I64, CT_U64, CT_F64, CT_TS: w = 2'd3;
      default: w = 2'd0;
    endcase
    return w;
  endfunction

  function automatic logic fixed_known(input logic [3:0] ct);
    return ct <= CT_TS;
  endfunction

endpackage

// ===== rtl/plain_column_payload_decoder.sv =====
// Plain column payload decoder. Payload bytes enter one per transaction on the
// input channel and the block takes one byte per clock cycle unless stalled:
// each byte waits in an input register, passes through the decode logic, and
// its results (at most one row and, on the byte flagged payload_end, the final
// status) land in a four-entry output queue. The input stalls only when that
// queue holds more than two results, so with a consumer that keeps up the
// sustained rate is one byte per cycle. A result reaches the output by way of
// the input register and then the output queue. Rows with a cleared validity
// bit are reported null. The status transaction always comes last and carries
// the first error in the format's check order; rows of a chunk that ends with
// a nonzero status should be discarded. Configuration (column type, row count,
// declared nulls) is written through the cfg channel, which is always ready;
// the user must write it only while no chunk is in flight, which the block
// itself does not enforce. The bitmap store holds (MAX_ROWS+7)/8 bytes and
// needs no clearing after reset.
module plain_column_payload_decoder import pcpd_pkg::*; #(
  parameter int MAX_ROWS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  payload_byte,
  input  logic        payload_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        item_kind,
  output logic [15:0] row_number,
  output logic [63:0] row_value,
  output logic [30:0] value_len,
  output logic        row_is_null,
  output logic [3:0]  status_code,
  output logic        end_of_chunk
);

  cfg_t       cfg;
  logic       inq_valid;
  logic [7:0] inq_byte;
  logic       inq_end;
  logic       fire;
  logic       room2;
  logic [1:0] push_n;
  result_t    res0;
  result_t    res1;
  result_t    head;

  assign cfg_ready = 1'b1;

  // Register writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COLUMN_TYPE: cfg.column_type <= cfg_data[3:0];
        REG_ROWS: cfg.rows_in_chunk <= cfg_data;
        REG_NULLS: cfg.declared_nulls <= cfg_data;
        default: ;
      endcase
    end
  end

  // A byte is decoded only when the queue can take both of its results.
  assign fire = inq_valid && room2;
  assign in_ready = !inq_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_byte <= payload_byte;
      inq_end <= payload_end;
    end
  end

  pcpd_core #(.MAX_ROWS(MAX_ROWS)) u_core (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .fire(fire),
    .byte_in(inq_byte),
    .end_in(inq_end),
    .push_n(push_n),
    .res0(res0),
    .res1(res1)
  );

  pcpd_out_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push_n(push_n),
    .wr0(res0),
    .wr1(res1),
    .room2(room2),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head(head)
  );

  assign item_kind = head.kind;
  assign row_number = head.row;
  assign row_value = head.value;
  assign value_len = head.len;
  assign row_is_null = head.is_null;
  assign status_code = head.code;
  assign end_of_chunk = head.eoc;

endmodule

// ===== rtl/pcpd_out_fifo.sv =====
`include "plain_column_payload_decoder_assert.svh"

module pcpd_out_fifo import pcpd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic [1:0] push_n,
  input  result_t wr0,
  input  result_t wr1,
  output logic    room2,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t head
);

  localparam int DEPTH = 4;

  result_t    mem [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign out_valid = count != 3'd0;
  assign pop = out_valid && out_ready;
  assign room2 = count <= 3'(DEPTH - 2);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= wr0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + 2'd1] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, push_n} - {2'b0, pop};
    end
  end

  `PCPD_CHECK(a_no_overflow, ({1'b0, count} + {2'b0, push_n}) <= (4'(DEPTH) + {3'b0, pop}))
  `PCPD_CHECK_NEXT(a_pop_only, pop && (push_n == 2'd0), count == $past(count) - 3'd1)
  `PCPD_CHECK(a_status_last, (push_n != 2'd2) || (wr1.kind && !wr0.kind))

endmodule

// ===== rtl/pcpd_core.sv =====
module pcpd_core import pcpd_pkg::*; #(
  parameter int MAX_ROWS = 65536
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       fire,
  input  logic [7:0] byte_in,
  input  logic       end_in,
  output logic [1:0] push_n,
  output result_t    res0,
  output result_t    res1
);

  localparam int STORE = (MAX_ROWS + 7) / 8;
  localparam int SA = (STORE > 1) ? $clog2(STORE) : 1;
  localparam logic [20:0] MAXR = 21'(MAX_ROWS);
  localparam logic [63:0] STORE64 = 64'(STORE);

  logic [7:0] store [STORE];

  logic [2:0]       phase, phase_next;
  logic [63:0]      pos, pos_next;
  logic [63:0]      bm_len, bm_len_next;
  logic [63:0]      off_len, off_len_next;
  logic [63:0]      val_len, val_len_next;
  logic [ROW_W-1:0] tally, tally_next;
  logic [63:0]      asm_v, asm_next;
  logic [63:0]      prev_off, prev_off_next;
  logic [ROW_W-1:0] row_cnt, row_cnt_next;
  logic [13:0]      err, err_next;
  logic [7:0]       rd_data;

  logic [ROW_W-1:0] rows;
  logic [63:0]      rows64;
  logic             variable;
  logic [1:0]       wl2;
  logic [2:0]       wmask;
  logic             adv;
  logic [63:0]      part;
  logic [63:0]      asm_c;
  logic             nul;
  logic             row_emit;
  result_t          row_item;
  result_t          stat_item;
  logic             wr_en;
  logic [SA-1:0]    wr_addr;
  logic [SA-1:0]    rd_addr;
  logic [63:0]      rd_index;
  logic [ROW_W-1:0] rnext;
  logic [3:0]       zeros;
  logic [63:0]      len64;
  logic [63:0]      kidx;
  logic [13:0]      fin;
  logic [3:0]       code;
  logic [63:0]      expected;

  always_comb begin
    rows = ({4'b0, cfg.rows_in_chunk} > MAXR) ? MAXR[ROW_W-1:0] : cfg.rows_in_chunk;
    rows64 = {{(64-ROW_W){1'b0}}, rows};
    variable = (cfg.column_type == CT_STRING) || (cfg.column_type == CT_BINARY);
    wl2 = width_log2(cfg.column_type);
    wmask = 3'((4'd1 << wl2) - 4'd1);
    nul = ({{(64-ROW_W+3){1'b0}}, row_cnt[ROW_W-1:3]} < bm_len) &&
          !rd_data[row_cnt[2:0]];
  end

  always_comb begin
    phase_next = phase;
    pos_next = pos;
    bm_len_next = bm_len;
    off_len_next = off_len;
    val_len_next = val_len;
    tally_next = tally;
    asm_next = asm_v;
    prev_off_next = prev_off;
    row_cnt_next = row_cnt;
    err_next = err;
    adv = 1'b0;
    row_emit = 1'b0;
    row_item = '0;
    stat_item = '0;
    wr_en = 1'b0;
    zeros = '0;
    len64 = '0;
    kidx = pos >> 3;
    part = {56'b0, byte_in} << {pos[2:0], 3'b000};
    asm_c = asm_v | part;
    fin = '0;
    code = ST_OK;
    expected = '0;
    push_n = 2'd0;
    res0 = '0;
    res1 = '0;

    unique case (phase)
      PH_HEADER: begin
        if (pos[4:3] == 2'd0) begin
          bm_len_next = bm_len | part;
        end else if (pos[4:3] == 2'd1) begin
          off_len_next = off_len | part;
        end else begin
          val_len_next = val_len | part;
        end
        pos_next = pos + 64'd1;
        adv = pos_next >= 64'd24;
      end
      PH_BITMAP: begin
        if (pos < STORE64) begin
          wr_en = 1'b1;
          for (int i = 0; i < 8; i++) begin
            if (({pos[60:0], 3'(i)} < rows64) && !byte_in[i]) begin
              zeros = zeros + 4'd1;
            end
          end
          tally_next = tally + {{(ROW_W-4){1'b0}}, zeros};
        end
        if ((rows[2:0] != 3'd0) && (pos == (rows64 >> 3)) &&
            ((byte_in & (8'hFF << rows[2:0])) != 8'd0)) begin
          err_next[ST_PADDING] = 1'b1;
        end
        pos_next = pos + 64'd1;
        adv = pos_next == bm_len;
      end
      PH_OFFSETS: begin
        if (variable) begin
          asm_next = asm_c;
          if (pos[2:0] == 3'd7) begin
            if (((kidx != 64'd0) && (asm_c < prev_off)) || (asm_c > val_len)) begin
              err_next[ST_OFF_ORDER] = 1'b1;
            end
            if ((kidx == 64'd0) && (asm_c != 64'd0)) begin
              err_next[ST_OFF_NORM] = 1'b1;
            end
            if ((kidx == rows64) && (asm_c != val_len)) begin
              err_next[ST_OFF_NORM] = 1'b1;
            end
            if ((kidx != 64'd0) && (row_cnt < rows)) begin
              len64 = asm_c - prev_off;
              if (!nul && (len64 > 64'h7FFF_FFFF)) begin
                err_next[ST_TOO_LONG] = 1'b1;
              end
              row_emit = 1'b1;
              row_item.row = row_cnt[15:0];
              row_item.value = nul ? 64'd0 : prev_off;
              row_item.len = nul ? 31'd0 : len64[30:0];
              row_item.is_null = nul;
              row_cnt_next = row_cnt + 17'd1;
            end
            prev_off_next = asm_c;
            asm_next = '0;
          end
        end
        pos_next = pos + 64'd1;
        adv = pos_next == off_len;
      end
      PH_VALUES: begin
        if (!variable && fixed_known(cfg.column_type)) begin
          if ((cfg.column_type == CT_BOOL) && (byte_in > 8'd1)) begin
            err_next[ST_BAD_BOOL] = 1'b1;
          end
          asm_c = asm_v | ({56'b0, byte_in} << {(pos[2:0] & wmask), 3'b000});
          asm_next = asm_c;
          if ((pos[2:0] & wmask) == wmask) begin
            if (row_cnt < rows) begin
              row_emit = 1'b1;
              row_item.row = row_cnt[15:0];
              row_item.value = nul ? 64'd0 : asm_c;
              row_item.is_null = nul;
              row_cnt_next = row_cnt + 17'd1;
            end
            asm_next = '0;
          end
        end
        pos_next = pos + 64'd1;
        adv = pos_next == val_len;
      end
      default: begin
        err_next[ST_TRAILING] = 1'b1;
      end
    endcase

    // Moving on skips every section that turned out to be empty.
    if (adv) begin
      pos_next = '0;
      asm_next = '0;
      if ((phase == PH_HEADER) && (bm_len_next != 64'd0)) begin
        phase_next = PH_BITMAP;
      end else if ((phase <= PH_BITMAP) && (off_len_next != 64'd0)) begin
        phase_next = PH_OFFSETS;
      end else if ((phase <= PH_OFFSETS) && (val_len_next != 64'd0)) begin
        phase_next = PH_VALUES;
      end else begin
        phase_next = PH_DONE;
      end
    end

    if (end_in) begin
      fin = err_next;
      expected = (cfg.declared_nulls == '0) ? 64'd0 : ((rows64 + 64'd7) >> 3);
      if (phase_next != PH_DONE) fin[ST_TRUNC] = 1'b1;
      if (bm_len_next != expected) fin[ST_BM_LEN] = 1'b1;
      if (tally_next != cfg.declared_nulls) fin[ST_NULLS] = 1'b1;
      if (variable) begin
        if (off_len_next != ((rows64 + 64'd1) << 3)) fin[ST_OFF_LEN] = 1'b1;
      end else if (fixed_known(cfg.column_type)) begin
        if (off_len_next != 64'd0) fin[ST_FIXED_OFF] = 1'b1;
        if (val_len_next != (rows64 << wl2)) fin[ST_VAL_LEN] = 1'b1;
      end else begin
        fin[ST_UNKNOWN] = 1'b1;
      end
      for (int c = 13; c >= 1; c--) begin
        if (fin[c]) code = 4'(c);
      end
      stat_item.kind = 1'b1;
      stat_item.code = code;
      stat_item.eoc = 1'b1;
      phase_next = PH_HEADER;
      pos_next = '0;
      bm_len_next = '0;
      off_len_next = '0;
      val_len_next = '0;
      tally_next = '0;
      asm_next = '0;
      prev_off_next = '0;
      row_cnt_next = '0;
      err_next = '0;
    end

    if (fire) begin
      if (row_emit) begin
        res0 = row_item;
        res1 = stat_item;
        push_n = end_in ? 2'd2 : 2'd1;
      end else if (end_in) begin
        res0 = stat_item;
        push_n = 2'd1;
      end
    end
  end

  always_comb begin
    rnext = fire ? row_cnt_next : row_cnt;
    rd_index = {{(64-ROW_W+3){1'b0}}, rnext[ROW_W-1:3]};
    rd_addr = rd_index[SA-1:0];
    wr_addr = pos[SA-1:0];
  end

  // The store reads one row byte ahead; a write to the same byte passes through.
  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      store[wr_addr] <= byte_in;
    end
    if (fire && wr_en && (wr_addr == rd_addr)) begin
      rd_data <= byte_in;
    end else begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      pos <= '0;
      bm_len <= '0;
      off_len <= '0;
      val_len <= '0;
      tally <= '0;
      asm_v <= '0;
      prev_off <= '0;
      row_cnt <= '0;
      err <= '0;
    end else if (fire) begin
      phase <= phase_next;
      pos <= pos_next;
      bm_len <= bm_len_next;
      off_len <= off_len_next;
      val_len <= val_len_next;
      tally <= tally_next;
      asm_v <= asm_next;
      prev_off <= prev_off_next;
      row_cnt <= row_cnt_next;
      err <= err_next;
    end
  end

endmodule

// ===== verif/tb_plain_column_payload_decoder.sv =====
`timescale 1ns / 100ps

module tb_plain_column_payload_decoder;
  import pcpd_pkg::*;

  // Column type code with no defined meaning.
  localparam logic [3:0] CT_RESERVED = 4'd15;

  localparam int STORE_DEPTH = 8192;
  localparam int ROW_CAP = 65536;
  localparam int CYCLE_LIMIT = 2000000;

  // Element width in bytes for a column type, 0 when the type has no fixed width.
  function automatic int elem_width(input logic [3:0] ct);
    case (ct)
      CT_BOOL, CT_I8, CT_U8: return 1;
      CT_I16, CT_U16: return 2;
      CT_I32, CT_U32, CT_F32: return 4;
      CT_I64, CT_U64, CT_F64, CT_TS: return 8;
      default: return 0;
    endcase
  endfunction

  // The scoreboard keeps its own copy of the decoder state and the expected
  // results of every accepted payload byte, oldest first.
  class chunk_scoreboard;
    logic [3:0]  ctype;
    logic [16:0] rows_cfg;
    logic [16:0] nulls_cfg;
    logic [2:0]  phase;
    logic [63:0] pos, bm_len, off_len, val_len, assembly, prev_off;
    logic [7:0]  store [STORE_DEPTH];
    logic [16:0] null_cnt, row_cnt;
    logic [13:0] flags;
    result_t     expected_rows[$];
    int          errors;

    function new();
      ctype = CT_BOOL;
      rows_cfg = '0;
      nulls_cfg = '0;
      errors = 0;
      foreach (store[i]) store[i] = 8'h00;
      clear_chunk();
    endfunction

    function void clear_chunk();
      phase = PH_HEADER;
      pos = '0;
      bm_len = '0;
      off_len = '0;
      val_len = '0;
      assembly = '0;
      prev_off = '0;
      null_cnt = '0;
      row_cnt = '0;
      flags = '0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [16:0] data);
      case (idx)
        REG_COLUMN_TYPE: ctype = data[3:0];
        REG_ROWS: rows_cfg = data;
        REG_NULLS: nulls_cfg = data;
        default: ;
      endcase
    endfunction

    function logic [63:0] rows_eff();
      return (rows_cfg > ROW_CAP) ? 64'(ROW_CAP) : 64'(rows_cfg);
    endfunction

    function bit variable_type();
      return ctype == CT_STRING || ctype == CT_BINARY;
    endfunction

    function void raise(input logic [3:0] code);
      flags[code] = 1'b1;
    endfunction

    // Skip over empty sections after the one that just finished.
    function void next_section(input logic [2:0] from);
      logic [2:0] p;
      p = from + 3'd1;
      pos = '0;
      assembly = '0;
      if (p == PH_BITMAP && bm_len != 0) phase = PH_BITMAP;
      else if (p <= PH_OFFSETS && off_len != 0) phase = PH_OFFSETS;
      else if (p <= PH_VALUES && val_len != 0) phase = PH_VALUES;
      else phase = PH_DONE;
    endfunction

    function bit null_at(input logic [63:0] row);
      logic [63:0] b;
      b = row >> 3;
      if (bm_len == 0 || b >= bm_len || b >= STORE_DEPTH) return 1'b0;
      return store[b[12:0]][row[2:0]] == 1'b0;
    endfunction

    function void push_result(input logic kind, input logic [15:0] row,
                              input logic [63:0] value, input logic [30:0] len,
                              input logic is_null, input logic [3:0] code);
      result_t r;
      r.kind = kind;
      r.row = row;
      r.value = value;
      r.len = len;
      r.is_null = is_null;
      r.code = code;
      r.eoc = kind;
      expected_rows = {expected_rows, r};
    endfunction

    function logic [3:0] chunk_status();
      logic [63:0] rows, bm_want, w;
      rows = rows_eff();
      w = 64'(elem_width(ctype));
      bm_want = (nulls_cfg == 0) ? 64'd0 : (rows + 7) / 8;
      if (phase != PH_DONE) raise(ST_TRUNC);
      if (bm_len != bm_want) raise(ST_BM_LEN);
      if (null_cnt != nulls_cfg) raise(ST_NULLS);
      if (variable_type()) begin
        if (off_len != (rows + 1) * 8) raise(ST_OFF_LEN);
      end else if (w != 0) begin
        if (off_len != 0) raise(ST_FIXED_OFF);
        if (val_len != rows * w) raise(ST_VAL_LEN);
      end else begin
        raise(ST_UNKNOWN);
      end
      for (int c = 1; c <= 13; c++)
        if (flags[c]) return 4'(c);
      return ST_OK;
    endfunction

    // Advance the copy of the decoder by one accepted payload byte.
    function void note_byte(input logic [7:0] b, input logic last);
      logic [63:0] rows, part, k, off, len, w, sub;
      logic [7:0]  pad_mask;
      bit          nul;
      rows = rows_eff();
      case (phase)
        PH_HEADER: begin
          part = {56'd0, b} << (pos[2:0] * 8);
          if (pos < 8) bm_len |= part;
          else if (pos < 16) off_len |= part;
          else val_len |= part;
          pos = pos + 1;
          if (pos >= 24) next_section(PH_HEADER);
        end
        PH_BITMAP: begin
          if (pos < STORE_DEPTH) begin
            store[pos[12:0]] = b;
            for (int i = 0; i < 8; i++)
              if (pos * 8 + i < rows && !b[i]) null_cnt = null_cnt + 17'd1;
          end
          pad_mask = 8'hFF << rows[2:0];
          if (rows[2:0] != 0 && pos == rows / 8 && (b & pad_mask) != 0) raise(ST_PADDING);
          pos = pos + 1;
          if (pos == bm_len) next_section(PH_BITMAP);
        end
        PH_OFFSETS: begin
          if (variable_type()) begin
            assembly |= {56'd0, b} << (pos[2:0] * 8);
            if (pos[2:0] == 3'd7) begin
              k = pos >> 3;
              off = assembly;
              if ((k > 0 && off < prev_off) || off > val_len) raise(ST_OFF_ORDER);
              if (k == 0 && off != 0) raise(ST_OFF_NORM);
              if (k == rows && off != val_len) raise(ST_OFF_NORM);
              if (k >= 1 && row_cnt < rows) begin
                nul = null_at(64'(row_cnt));
                len = off - prev_off;
                if (!nul && len > 64'h7FFF_FFFF) raise(ST_TOO_LONG);
                push_result(1'b0, row_cnt[15:0], nul ? 64'd0 : prev_off,
                            nul ? 31'd0 : len[30:0], nul, ST_OK);
                row_cnt = row_cnt + 17'd1;
              end
              prev_off = off;
              assembly = '0;
            end
          end
          pos = pos + 1;
          if (pos == off_len) next_section(PH_OFFSETS);
        end
        PH_VALUES: begin
          w = 64'(elem_width(ctype));
          if (!variable_type() && w != 0) begin
            if (ctype == CT_BOOL && b > 8'd1) raise(ST_BAD_BOOL);
            sub = pos & (w - 1);
            assembly |= {56'd0, b} << (sub * 8);
            if (sub == w - 1) begin
              if (row_cnt < rows) begin
                nul = null_at(64'(row_cnt));
                push_result(1'b0, row_cnt[15:0], nul ? 64'd0 : assembly, 31'd0,
                            nul, ST_OK);
                row_cnt = row_cnt + 17'd1;
              end
              assembly = '0;
            end
          end
          pos = pos + 1;
          if (pos == val_len) next_section(PH_VALUES);
        end
        default: raise(ST_TRAILING);
      endcase
      if (last) begin
        push_result(1'b1, 16'd0, 64'd0, 31'd0, 1'b0, chunk_status());
        clear_chunk();
      end
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (expected_rows.size() == 0) begin
        $error("unexpected result transaction: kind %0d row %0d", got.kind, got.row);
        errors++;
        return;
      end
      want = expected_rows.pop_front();
      if (got.kind !== want.kind) begin
        $error("item_kind expected %0d got %0d", want.kind, got.kind); errors++;
      end
      if (got.row !== want.row) begin
        $error("row_number expected %0d got %0d", want.row, got.row); errors++;
      end
      if (got.value !== want.value) begin
        $error("row_value expected %h got %h", want.value, got.value); errors++;
      end
      if (got.len !== want.len) begin
        $error("value_len expected %0d got %0d", want.len, got.len); errors++;
      end
      if (got.is_null !== want.is_null) begin
        $error("row_is_null expected %0d got %0d", want.is_null, got.is_null); errors++;
      end
      if (got.code !== want.code) begin
        $error("status_code expected %0d got %0d", want.code, got.code); errors++;
      end
      if (got.eoc !== want.eoc) begin
        $error("end_of_chunk expected %0d got %0d", want.eoc, got.eoc); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  payload_byte;
  logic        payload_end;
  logic        out_valid;
  logic        out_ready;
  logic        item_kind;
  logic [15:0] row_number;
  logic [63:0] row_value;
  logic [30:0] value_len;
  logic        row_is_null;
  logic [3:0]  status_code;
  logic        end_of_chunk;

  plain_column_payload_decoder DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .payload_byte(payload_byte),
    .payload_end(payload_end),
    .out_valid(out_valid), .out_ready(out_ready), .item_kind(item_kind),
    .row_number(row_number), .row_value(row_value), .value_len(value_len),
    .row_is_null(row_is_null), .status_code(status_code), .end_of_chunk(end_of_chunk)
  );

  chunk_scoreboard sb = new();

  // Percentages of cycles in which the sender idles and the receiver stalls,
  // set per phase by the stimulus process.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // Cycles of forced receiver hold-off; the receiver process counts it down.
  int hold_off_left = 0;
  int bytes_sent = 0;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every input starts at a known value; reset is released on a falling edge.
  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_COLUMN_TYPE;
    cfg_data = '0;
    in_valid = 1'b0;
    payload_byte = '0;
    payload_end = 1'b0;
    out_ready = 1'b0;
  end

  // The run is cut off at a generous cycle limit, far beyond the slowest
  // correct run with every stall in place.
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: ready changes only on falling edges. A pending hold-off keeps it
  // low for that many cycles so that the block's output queue fills up and it
  // must stall its input channel.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ready = 1'b0;
        hold_off_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Every transaction is observed at the rising edge, where the values seen
  // are the ones that were stable during the cycle before it.
  always @(posedge clk) begin
    result_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_byte(payload_byte, payload_end);
      if (out_valid && out_ready) begin
        got.kind = item_kind;
        got.row = row_number;
        got.value = row_value;
        got.len = value_len;
        got.is_null = row_is_null;
        got.code = status_code;
        got.eoc = end_of_chunk;
        sb.check_result(got);
      end
    end
  end

  // Offers one payload byte, with random idle cycles first, and returns once
  // the transaction has been accepted.
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    payload_byte = b;
    payload_end = last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_chunk(input logic [7:0] bytes[$]);
    if (bytes.size() == 0) bytes = {bytes, 8'($urandom)};
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Waits until every expected result has come back, then lets the pipeline
  // run empty, since a byte with no result may still be in flight.
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [16:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input logic [3:0] ct, input logic [16:0] rows,
                           input logic [16:0] nulls);
    wait_idle();
    write_cfg(REG_COLUMN_TYPE, {13'd0, ct});
    write_cfg(REG_ROWS, rows);
    write_cfg(REG_NULLS, nulls);
  endtask

  function automatic void put_le64(ref logic [7:0] q[$], input logic [63:0] v);
    for (int i = 0; i < 8; i++) q = {q, v[8*i +: 8]};
  endfunction

  // Builds a well-formed chunk for the given layout, optionally breaks it,
  // writes the configuration and streams it.
  task automatic run_chunk(input logic [3:0] ct, input int rows, input int nulls,
                           input bit broken);
    logic [7:0]  q[$];
    logic [7:0]  bitmap[$];
    logic [7:0]  offs[$];
    logic [7:0]  vals[$];
    bit          is_null[$];
    int          left, w, cut, len, total;
    logic [63:0] big;
    left = nulls;
    for (int i = 0; i < rows; i++) begin
      if (left > 0 && $urandom_range(rows - i - 1) < left) begin
        is_null = {is_null, 1'b1};
        left--;
      end else begin
        is_null = {is_null, 1'b0};
      end
    end
    if (nulls > 0) begin
      for (int b = 0; b < (rows + 7) / 8; b++) begin
        logic [7:0] v;
        v = 8'h00;
        for (int i = 0; i < 8; i++)
          if (b * 8 + i < rows) v[i] = !is_null[b * 8 + i];
        bitmap = {bitmap, v};
      end
    end
    w = elem_width(ct);
    if (ct == CT_STRING || ct == CT_BINARY) begin
      total = 0;
      put_le64(offs, 64'd0);
      for (int i = 0; i < rows; i++) begin
        len = is_null[i] ? $urandom_range(1) : $urandom_range(5);
        total += len;
        put_le64(offs, 64'(total));
      end
      for (int i = 0; i < total; i++) vals = {vals, 8'($urandom)};
    end else if (w != 0) begin
      for (int i = 0; i < rows * w; i++)
        vals = {vals, (ct == CT_BOOL) ? 8'($urandom_range(1)) : 8'($urandom)};
    end
    // A wild offset entry gives decreasing, out-of-range or over-long values.
    if (broken && offs.size() > 8 && $urandom_range(1)) begin
      big = {$urandom, $urandom};
      if ($urandom_range(1)) big = big >> $urandom_range(63);
      cut = 8 * $urandom_range(offs.size() / 8 - 1);
      for (int i = 0; i < 8; i++) offs[cut + i] = big[8*i +: 8];
      broken = 1'b0;
    end
    put_le64(q, 64'(bitmap.size()));
    put_le64(q, 64'(offs.size()));
    put_le64(q, 64'(vals.size()));
    q = {q, bitmap, offs, vals};
    if (broken) begin
      case ($urandom_range(2))
        0: begin
          cut = $urandom_range(q.size() - 1);
          q[cut] = q[cut] ^ 8'($urandom_range(255, 1));
        end
        1: q = q[0:$urandom_range(q.size() - 1)];
        default: repeat ($urandom_range(3, 1)) q = {q, 8'($urandom)};
      endcase
    end
    configure(ct, 17'(rows), 17'(nulls));
    send_chunk(q);
  endtask

  task automatic random_chunk(input int max_rows);
    logic [3:0] ct;
    int rows, nulls;
    ct = 4'($urandom_range(15));
    rows = $urandom_range(max_rows);
    nulls = (rows > 0 && $urandom_range(9) < 6) ? $urandom_range(rows) : 0;
    run_chunk(ct, rows, nulls, $urandom_range(9) < 2);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int target);
    int start;
    wait_idle();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = bytes_sent;
    while (bytes_sent - start < target) random_chunk(24);
  endtask

  initial begin
    logic [7:0] q[$];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: a lone all-ones byte ends a truncated chunk, then a zero header
    // alone is a complete empty bool chunk under the reset configuration.
    q = {8'hFF};
    send_chunk(q);
    q = {};
    repeat (24) q = {q, 8'h00};
    send_chunk(q);

    // Saturating row count with the largest null count and an unknown type.
    // The bitmap is far shorter than the saturated row count needs.
    configure(CT_RESERVED, 17'h1FFFF, 17'h1FFFF);
    q = {};
    put_le64(q, 64'd16);
    put_le64(q, 64'd0);
    put_le64(q, 64'd0);
    repeat (16) q = {q, 8'($urandom)};
    send_chunk(q);

    // A long receiver hold-off while one-byte rows keep streaming in.
    wait_idle();
    hold_off_left = 400;
    run_chunk(CT_U8, 60, 7, 1'b0);

    run_phase(0, 0, 110);
    run_chunk(CT_I16, 20, 4, 1'b0);
    run_chunk(CT_STRING, 12, 0, 1'b0);
    run_phase(70, 0, 110);
    run_phase(0, 70, 110);
    run_phase(38, 38, 110);

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
